// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the stripper RTL.
// Included by asp_parser.sv and asp_out_fifo.sv; expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks prop on every clock edge outside reset.
`define ASP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checks that cons holds in the cycle after ante.
`define ASP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) ante |=> cons) else $error(msg);
`else
`define ASP_ASSERT(lbl, prop, msg)
`define ASP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/asp_pkg.sv -----
// Types and constants for the ANSI SGR stripper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package asp_pkg;

    // Stream characters
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_FINAL    = 8'h6D;
    localparam logic [7:0] CH_SEP      = 8'h3B;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;

    localparam int PARAM_MAX = 255;
    localparam int PROD_W    = 12;  // 255*10 + 9 fits

    // Result status codes
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_BADCHAR = 2'd2;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_IGNORE = 1'b0;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_SEQ  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Up to two results produced by one input beat
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/asp_parser.sv -----
// Escape sequence parser: state registers plus per-beat result generation.
// Depends on asp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asp_parser (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          ignore_errors,
    output asp_pkg::push_t     push
);
    import asp_pkg::*;

    mode_t              mode_reg,   mode_next;
    logic [7:0]         param_reg,  param_next;
    logic               halted_reg, halted_next;

    logic               is_digit, is_sep, is_final, is_esc, is_lbr, bad_char;
    logic [3:0]         digit;
    logic [PROD_W-1:0]  prod;
    logic               overflow;

    assign is_digit = (in_byte >= CH_DIGIT_LO) && (in_byte <= CH_DIGIT_HI);
    assign is_sep   = (in_byte == CH_SEP);
    assign is_final = (in_byte == CH_FINAL);
    assign is_esc   = (in_byte == CH_ESC);
    assign is_lbr   = (in_byte == CH_LBRACKET);
    assign bad_char = !is_digit && !is_sep && !is_final;
    assign digit    = 4'(in_byte - CH_DIGIT_LO);

    // param*10 + digit as (p<<3) + (p<<1) + d
    assign prod = {1'b0, param_reg, 3'b000} + {3'b000, param_reg, 1'b0}
                + {8'h00, digit};
    assign overflow = (prod > PROD_W'(PARAM_MAX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_TEXT;
            param_reg  <= '0;
            halted_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            param_reg  <= param_next;
            halted_reg <= halted_next;
        end
    end

    // Next state
    always_comb begin
        mode_next   = mode_reg;
        param_next  = param_reg;
        halted_next = halted_reg;
        if (accept && !halted_reg) begin
            unique case (mode_reg)
                MODE_ESC: begin
                    if (is_lbr) begin
                        mode_next  = MODE_SEQ;
                        param_next = '0;
                    end else begin
                        mode_next = MODE_TEXT;
                    end
                end
                MODE_SEQ: begin
                    priority if (is_digit && !overflow) begin
                        param_next = prod[7:0];
                    end else if (is_sep) begin
                        param_next = '0;
                    end else if (is_final) begin
                        mode_next  = MODE_TEXT;
                        param_next = '0;
                    end else begin
                        // overflowing digit or bad character
                        mode_next   = MODE_TEXT;
                        param_next  = '0;
                        halted_next = !ignore_errors;
                    end
                end
                default: begin
                    mode_next = is_esc ? MODE_ESC : MODE_TEXT;
                end
            endcase
        end
    end

    // Results for this beat
    always_comb begin
        push = '0;
        if (accept && !halted_reg) begin
            unique case (mode_reg)
                MODE_ESC: begin
                    if (!is_lbr) begin
                        push.num = 2'd2;
                        push.r0  = '{out_byte: CH_ESC,  status: ST_DATA, last: 1'b0};
                        push.r1  = '{out_byte: in_byte, status: ST_DATA, last: 1'b1};
                    end
                end
                MODE_SEQ: begin
                    if (!ignore_errors) begin
                        if (is_digit && overflow) begin
                            push.num = 2'd1;
                            push.r0  = '{out_byte: 8'h00, status: ST_RANGE, last: 1'b1};
                        end else if (bad_char) begin
                            push.num = 2'd1;
                            push.r0  = '{out_byte: 8'h00, status: ST_BADCHAR, last: 1'b1};
                        end
                    end
                end
                default: begin
                    if (!is_esc) begin
                        push.num = 2'd1;
                        push.r0  = '{out_byte: in_byte, status: ST_DATA, last: 1'b1};
                    end
                end
            endcase
        end
    end

    `ASP_ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg, "halt cleared without reset")
    `ASP_ASSERT(a_halt_silent, !halted_reg || (push.num == 2'd0), "result while halted")

endmodule

`default_nettype wire

// ----- hw/rtl/asp_out_fifo.sv -----
// Result queue: takes up to two results per cycle, emits one per cycle while m_ready is high.
// Depends on asp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asp_out_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire asp_pkg::push_t push,
    output logic               space_ok,
    output logic               m_valid,
    input  wire logic          m_ready,
    output asp_pkg::result_t   m_data
);
    import asp_pkg::*;

    result_t            entries_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               pop;

    assign m_valid  = (count_reg != '0);
    assign m_data   = entries_reg[rd_ptr_reg];
    assign pop      = m_valid && m_ready;
    // room for the worst case of two results
    assign space_ok = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.num == 2'd2) begin
            entries_reg[wr_ptr_reg + PTR_W'(1)] <= push.r1;
        end
    end

    `ASP_ASSERT(a_no_overfill,
                (push.num == 2'd0) || (count_reg <= CNT_W'(FIFO_DEPTH - 2)),
                "push without room")
    `ASP_ASSERT_NEXT(a_pop_count, pop && (push.num == 2'd0),
                     count_reg == $past(count_reg) - CNT_W'(1), "pop count")

endmodule

`default_nettype wire

// ----- hw/rtl/ansi_sgr_stripper.sv -----
// Top level of the ANSI SGR stripper: APB register, parser and result queue.
// Depends on asp_pkg, asp_parser and asp_out_fifo.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+---------------------------------
//   s_      | in        | s_valid/s_ready  | s_in_byte[7:0]
//   m_      | out       | m_valid/m_ready  | m_out_byte[7:0] m_status[1:0] m_last
//   apb     | in        | psel/penable     | paddr[2:0] pwdata/prdata[31:0]
//
// One input beat per cycle while s_ready is high; the parser updates its state in
// the same cycle the beat is accepted and pushes zero, one or two results into a
// 4-deep queue. Results leave one per cycle while m_ready is high, so ESC plus a
// non-'[' byte yields two results. s_ready drops only while fewer than two queue
// slots are free (i.e. when the output side stalls). Synchronous active-low reset
// clears the parser, the queue and ignore_errors; no clearing pass is needed.
// Register 0 (byte address 0): bit 0 = ignore_errors.
`timescale 1ns / 1ps
`default_nettype none

module ansi_sgr_stripper (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input byte stream
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_in_byte,
    // result stream
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_out_byte,
    output logic [1:0]                         m_status,
    output logic                               m_last,
    // APB config port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [asp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [asp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [asp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import asp_pkg::*;

    logic       ignore_reg;
    logic       accept;
    logic       reg_hit;
    push_t      push;
    result_t    m_data;

    // ---- config register ----
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_IDX_IGNORE);  // word index

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            ignore_reg <= pwdata[0];
        end
    end

    assign prdata = reg_hit ? {{(APB_DATA_W-1){1'b0}}, ignore_reg} : '0;

    // ---- input beat ----
    assign accept = s_valid && s_ready;

    asp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .in_byte       (s_in_byte),
        .ignore_errors (ignore_reg),
        .push          (push)
    );

    // ---- result queue ----
    asp_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign m_out_byte = m_data.out_byte;
    assign m_status   = m_data.status;
    assign m_last     = m_data.last;

endmodule

`default_nettype wire

// ----- sim/asp_stream_checker.sv -----
// Scoreboard for the ANSI SGR stripper: snoops the APB port, predicts results per input beat.
// Depends on asp_pkg for the result struct, parse modes, characters and status codes.
`timescale 1ns / 1ps

module asp_stream_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [7:0]                        s_in_byte,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [7:0]                        m_out_byte,
    input  logic [1:0]                        m_status,
    input  logic                              m_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [asp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [asp_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic [asp_pkg::APB_DATA_W-1:0]    prdata,
    output int                                mismatches,
    output int                                outstanding,
    output int                                checked
);
    import asp_pkg::*;

    localparam logic [APB_ADDR_W-1:0] IGNORE_ADDR = APB_ADDR_W'(4 * REG_IDX_IGNORE);
    localparam int RADIX     = 10;
    localparam int MAX_SHOWN = 16;

    // shadow of the register and the parser state
    logic       ignore_errors;
    mode_t      mode;
    logic [7:0] param;
    logic       halted;

    result_t    expected_results[$];
    result_t    want;
    bit         bad;

    task automatic push_result(input logic [7:0] b, input logic [1:0] st, input logic lst);
        result_t r;
        r.out_byte = b;
        r.status   = st;
        r.last     = lst;
        expected_results.push_back(r);
    endtask

    task automatic seq_error(input logic [1:0] st);
        mode  = MODE_TEXT;
        param = 8'h00;
        if (!ignore_errors) begin
            halted = 1'b1;
            push_result(8'h00, st, 1'b1);
        end
    endtask

    task automatic strip_byte(input logic [7:0] c);
        int acc;
        if (halted)
            return;
        case (mode)
            MODE_ESC: begin
                if (c == CH_LBRACKET) begin
                    mode  = MODE_SEQ;
                    param = 8'h00;
                end else begin
                    mode = MODE_TEXT;
                    push_result(CH_ESC, ST_DATA, 1'b0);
                    push_result(c, ST_DATA, 1'b1);
                end
            end
            MODE_SEQ: begin
                if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
                    acc = int'(param) * RADIX + int'(c - CH_DIGIT_LO);
                    if (acc > PARAM_MAX)
                        seq_error(ST_RANGE);
                    else
                        param = 8'(acc);
                end else if (c == CH_SEP) begin
                    param = 8'h00;
                end else if (c == CH_FINAL) begin
                    mode  = MODE_TEXT;
                    param = 8'h00;
                end else begin
                    seq_error(ST_BADCHAR);
                end
            end
            default: begin
                // text, and the unused mode code
                mode = MODE_TEXT;
                if (c == CH_ESC)
                    mode = MODE_ESC;
                else
                    push_result(c, ST_DATA, 1'b1);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ignore_errors = 1'b0;
            mode          = MODE_TEXT;
            param         = 8'h00;
            halted        = 1'b0;
            expected_results.delete();
            mismatches    = 0;
            checked       = 0;
        end else begin
            // results first, so a beat pushed at this edge cannot hide an unexpected one
            if (m_valid && m_ready) begin
                checked++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: unexpected result beat byte %02h status %0d last %0d",
                                 $time, m_out_byte, m_status, m_last);
                end else begin
                    want = expected_results.pop_front();
                    bad  = 0;
                    if (m_out_byte !== want.out_byte) begin
                        bad = 1;
                        if (mismatches < MAX_SHOWN)
                            $display("%0t: out_byte expected %02h got %02h",
                                     $time, want.out_byte, m_out_byte);
                    end
                    if (m_status !== want.status) begin
                        bad = 1;
                        if (mismatches < MAX_SHOWN)
                            $display("%0t: status expected %0d got %0d",
                                     $time, want.status, m_status);
                    end
                    if (m_last !== want.last) begin
                        bad = 1;
                        if (mismatches < MAX_SHOWN)
                            $display("%0t: last expected %0d got %0d",
                                     $time, want.last, m_last);
                    end
                    if (bad)
                        mismatches++;
                end
            end
            if (s_valid && s_ready)
                strip_byte(s_in_byte);
            if (psel && penable && pready && paddr == IGNORE_ADDR) begin
                if (pwrite) begin
                    ignore_errors = pwdata[0];
                end else if (prdata !== APB_DATA_W'(ignore_errors)) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: prdata expected %08h got %08h",
                                 $time, APB_DATA_W'(ignore_errors), prdata);
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the ANSI SGR stripper bench: clock, reset, stimulus, result sink and verdict.
// Depends on asp_pkg, the ansi_sgr_stripper RTL and asp_stream_checker.
`timescale 1ns / 1ps

module testbench;
    import asp_pkg::*;

    localparam logic [APB_ADDR_W-1:0] IGNORE_ADDR = APB_ADDR_W'(4 * REG_IDX_IGNORE);
    // first byte address past the register map; writes there must be dropped
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(4);

    localparam int SETTLE_CYCLES  = 4;     // parser state settles in the accept cycle
    localparam int HOLD_AT        = 300;   // result beat count at which the sink stalls
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any beat

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic [7:0]               s_in_byte = 8'h00;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic [7:0]               m_out_byte;
    logic [1:0]               m_status;
    logic                     m_last;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr     = '0;
    logic [APB_DATA_W-1:0]    pwdata    = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    int mismatches;
    int outstanding;
    int checked;

    int sent       = 0;   // accepted input beats
    int reg_writes = 0;
    int idle_cycles = 0;
    bit s_fast     = 0;   // sender runs without gaps while set

    always #4 aclk = ~aclk;

    ansi_sgr_stripper dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_status   (m_status),
        .m_last     (m_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    asp_stream_checker scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_status    (m_status),
        .m_last      (m_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // Watchdog: any beat on either stream resets the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d results still expected",
                     $time, idle_cycles, outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result sink. Random gap before each beat, bursts with no gaps, and one long
    // hold-off so the 4-deep result queue fills and s_ready has to drop.
    initial begin : result_sink
        int  gap;
        int  taken;
        bit  fast;
        taken = 0;
        fast  = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (taken % 40 == 0)
                fast = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = fast ? 0 : $urandom_range(0, 19);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
            @(negedge aclk);
        end
    end

    // One input beat. Entered and left at a falling edge; valid stays high on
    // return so a back-to-back beat needs no second assignment in the step.
    task automatic send(input logic [7:0] b);
        int gap;
        if (sent % 40 == 0)
            s_fast = ($urandom_range(0, 3) == 0);
        gap = s_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    // Drop valid, wait for every expected beat, then let the parser settle.
    task automatic settle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read-back is compared by the scoreboard
    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // decimal parameter, optionally with leading zeros
    task automatic send_number(input int v, input int zeros);
        logic [7:0] digs[$];
        repeat (zeros) send(CH_DIGIT_LO);
        do begin
            digs.push_front(8'(CH_DIGIT_LO + v % 10));
            v = v / 10;
        end while (v > 0);
        foreach (digs[i])
            send(digs[i]);
    endtask

    // ESC followed by anything but '[': both bytes come back out
    task automatic send_esc_pair();
        logic [7:0] b;
        send(CH_ESC);
        if ($urandom_range(0, 3) == 0)
            b = CH_ESC;
        else
            do b = 8'($urandom_range(0, 255)); while (b == CH_LBRACKET);
        send(b);
    endtask

    // byte that is illegal inside a sequence
    task automatic send_badchar();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) || b == CH_SEP || b == CH_FINAL);
        send(b);
    endtask

    // Plain text. In clean mode a stray ESC becomes an ESC pair, so the parser
    // never ends up inside a sequence by accident.
    task automatic send_text(input int count, input bit clean);
        logic [7:0] b;
        repeat (count) begin
            b = 8'($urandom_range(0, 255));
            if (clean && b == CH_ESC)
                send_esc_pair();
            else
                send(b);
        end
    endtask

    // well-formed SGR: 0..4 parameters, some empty, some padded with zeros
    task automatic send_sgr();
        int n;
        int v;
        send(CH_ESC);
        send(CH_LBRACKET);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                send(CH_SEP);
            if ($urandom_range(0, 5) != 0) begin
                v = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
                send_number(v, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            end
        end
        send(CH_FINAL);
    endtask

    // malformed or unterminated sequences, only sent with ignore_errors set
    task automatic send_broken();
        send(CH_ESC);
        send(CH_LBRACKET);
        case ($urandom_range(0, 3))
            0: send_number($urandom_range(256, 999), 0);
            1: begin
                if ($urandom_range(0, 1))
                    send_number($urandom_range(0, 255), 0);
                send_badchar();
            end
            2: begin
                send_number($urandom_range(0, 255), 0);
                send(CH_ESC);
            end
            default: send_number($urandom_range(0, 255), 0);  // left open
        endcase
    endtask

    // Random stream. Clean phases hold only legal input; noisy phases mix in
    // raw bytes and broken sequences and close with 'm', which returns the
    // parser to text from any mode.
    task automatic stream_phase(input int n, input bit clean);
        int stop;
        stop = sent + n;
        while (sent < stop) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_text($urandom_range(1, 8), clean);
                4, 5, 6:    send_sgr();
                7:          send_esc_pair();
                default: begin
                    if (clean)
                        send_sgr();
                    else
                        send_broken();
                end
            endcase
        end
        if (!clean)
            send(CH_FINAL);
    endtask

    initial begin : stimulus
        bit halt_on_range;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, halting mode: extremes, empty parameter, ESC pairs
        apb_write(IGNORE_ADDR, 32'd0);
        apb_read(IGNORE_ADDR);
        send(8'h00);
        send("A");
        send(CH_ESC); send(CH_LBRACKET); send_number(255, 0); send(CH_SEP); send(CH_FINAL);
        send(CH_ESC); send(CH_ESC);
        send(CH_ESC); send(8'hFF);
        // stop mid-sequence and switch to ignore mode; the next digit overflows
        send(CH_ESC); send(CH_LBRACKET); send_number(25, 0);
        settle();
        apb_write(IGNORE_ADDR, 32'd1);
        apb_read(IGNORE_ADDR);
        send(CH_DIGIT_LO + 8'd6);   // 256: dropped, back to text
        send(CH_DIGIT_LO + 8'd7);   // plain text again
        send(CH_ESC); send(CH_LBRACKET); send(CH_ESC);   // ESC inside a sequence
        send("q");

        // random phases over both settings; the write past the map must not
        // clear ignore mode, or the noisy phase would halt the block
        settle();
        apb_write(UNUSED_ADDR, 32'd0);
        stream_phase(600, 1'b0);
        settle();
        apb_write(IGNORE_ADDR, 32'd0);
        stream_phase(400, 1'b1);
        settle();
        apb_write(IGNORE_ADDR, 32'd1);
        apb_read(IGNORE_ADDR);
        stream_phase(400, 1'b0);
        settle();
        apb_write(IGNORE_ADDR, 32'd0);
        apb_read(IGNORE_ADDR);
        stream_phase(300, 1'b1);

        // halting error last: only reset clears it, and reset is not repeated
        settle();
        send_text(4, 1'b1);
        send_sgr();
        halt_on_range = 1'($urandom_range(0, 1));
        send(CH_ESC);
        send(CH_LBRACKET);
        if (halt_on_range) begin
            send_number($urandom_range(256, 999), 0);
        end else begin
            send_number($urandom_range(0, 255), 0);
            send_badchar();
        end
        // everything from here on is dropped
        send_text(10, 1'b0);
        send_sgr();

        settle();
        repeat (8) @(negedge aclk);
        $display("Summary: %0d input beats, %0d result beats checked, %0d register writes",
                 sent, checked, reg_writes);
        $display("Summary: both ignore_errors settings, halt forced by a %s error",
                 halt_on_range ? "parameter range" : "bad character");
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
